/* hdl/nfcrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcrp_pkg
// Shared types and constants for the NFC response frame parser.
// ----------------------------------------------------------------------------
package nfcrp_pkg;

    // Frame layout constants
    localparam logic [7:0] PREAMBLE_ZERO = 8'h00;
    localparam logic [7:0] PREAMBLE_END  = 8'hFF;
    localparam logic [7:0] DIR_TO_HOST   = 8'hD5;
    localparam logic [7:0] STATUS_MASK   = 8'h3F;
    localparam logic [7:0] HEADER_BYTES  = 8'd3;

    // Register reset values
    localparam logic [7:0] RESP_CODE_RESET   = 8'h41;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFF;

    // Register map
    localparam int          APB_ADDR_W   = 3;
    localparam int          APB_DATA_W   = 32;
    localparam logic        REG_RESP_CODE   = 1'b0;
    localparam logic        REG_MAX_PAYLOAD = 1'b1;

    // Result queue depth
    localparam int          RESQ_DEPTH = 4;
    localparam int          RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int          RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_DONE    = 4'd0,
        PH_PRE0    = 4'd1,
        PH_PRE1    = 4'd2,
        PH_PRE2    = 4'd3,
        PH_LEN     = 4'd4,
        PH_LCS     = 4'd5,
        PH_TFI     = 4'd6,
        PH_CODE    = 4'd7,
        PH_STATUS  = 4'd8,
        PH_PAYLOAD = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        V_OK       = 3'd0,
        V_PREAMBLE = 3'd1,
        V_LENGTH   = 3'd2,
        V_RESPONSE = 3'd3,
        V_STATUS   = 3'd4
    } verdict_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [2:0] verdict;
        logic [7:0] payload_count;
        logic       last;
    } result_t;

    // Results produced by one input byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    // Register values seen by the parser
    typedef struct packed {
        logic [7:0] expected_response_code;
        logic [7:0] max_payload_bytes;
    } cfg_t;

endpackage

/* hdl/nfcrp_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcrp_ifs
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface nfcrp_rx_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] rx_byte;

    modport source (output valid, output frame_start, output rx_byte, input ready);
    modport sink   (input valid, input frame_start, input rx_byte, output ready);
endinterface

interface nfcrp_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data;
    logic [2:0] verdict;
    logic [7:0] payload_count;
    logic       last;

    modport source (output valid, output kind, output data, output verdict,
                    output payload_count, output last, input ready);
    modport sink   (input valid, input kind, input data, input verdict,
                    input payload_count, input last, output ready);
endinterface

/* hdl/nfc_response_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_response_frame_parser
// Checks NFC controller response frames byte by byte and forwards payload.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake        Contents
//  rx        in    valid/ready      frame_start, rx_byte
//  res       out   valid/ready      kind, data, verdict, payload_count, last
//  APB       in    psel/penable     expected_response_code, max_payload_bytes
//
//  One received byte per cycle; each byte is checked in the cycle it is taken
//  and its results (zero, one or two) enter a four-entry result FIFO.
//  rx.ready is high while the FIFO can hold two more results, so with a
//  result taken every cycle the byte rate is one per clock.
//  The closing payload byte yields two results and drains in two transfers.
//  Reset leaves the parser waiting for a frame start, registers at defaults.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser
    import nfcrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    nfcrp_rx_if.sink              rx,
    nfcrp_res_if.source           res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t         cfg;
    result_pair_t results;
    logic         room;
    logic         accept;

    assign rx.ready = room;
    assign accept   = rx.valid & room;

    // Configuration registers
    nfcrp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame checker
    nfcrp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (rx.frame_start),
        .rx_byte     (rx.rx_byte),
        .cfg         (cfg),
        .results     (results)
    );

    // Result buffer
    nfcrp_result_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept ? results : '0),
        .room  (room),
        .res   (res)
    );

endmodule

/* hdl/nfcrp_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcrp_regs
// APB-style register file: expected response code and payload limit.
// ----------------------------------------------------------------------------
module nfcrp_regs
    import nfcrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [7:0] resp_code_reg;
    logic [7:0] max_payload_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes, decoded on the word index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_code_reg   <= RESP_CODE_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_RESP_CODE)
            begin
                resp_code_reg <= pwdata[7:0];
            end
            else
            begin
                max_payload_reg <= pwdata[7:0];
            end
        end
    end

    // Read back
    always_comb
    begin
        if (paddr[2] == REG_MAX_PAYLOAD)
        begin
            prdata = {{(APB_DATA_W-8){1'b0}}, max_payload_reg};
        end
        else
        begin
            prdata = {{(APB_DATA_W-8){1'b0}}, resp_code_reg};
        end
    end

    assign cfg.expected_response_code = resp_code_reg;
    assign cfg.max_payload_bytes      = max_payload_reg;

endmodule

/* hdl/nfcrp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcrp_parser
// Per-byte frame state machine; emits up to two results per accepted byte.
// ----------------------------------------------------------------------------
module nfcrp_parser
    import nfcrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         frame_start,
    input  logic [7:0]   rx_byte,
    input  cfg_t         cfg,
    output result_pair_t results
);

    phase_t     phase_reg,   phase_next;
    logic [7:0] len_reg,     len_next;
    logic [7:0] left_reg,    left_next;
    logic [7:0] count_reg,   count_next;

    // State registers, advanced only on an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            len_reg   <= 8'd0;
            left_reg  <= 8'd0;
            count_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

    // Next state and results
    always_comb
    begin
        phase_t     ph;
        logic [7:0] len_sum;
        logic [7:0] n_payload;
        logic [7:0] count_inc;
        logic [7:0] left_dec;
        logic       fail;
        verdict_t   fail_code;

        // frame start restarts the parser on this byte
        ph         = frame_start ? PH_PRE0 : phase_reg;
        len_next   = frame_start ? 8'd0 : len_reg;
        left_next  = frame_start ? 8'd0 : left_reg;
        count_next = frame_start ? 8'd0 : count_reg;
        phase_next = ph;

        len_sum   = len_next + rx_byte;
        n_payload = len_next - HEADER_BYTES;
        if (n_payload > cfg.max_payload_bytes)
        begin
            n_payload = cfg.max_payload_bytes;
        end
        count_inc = count_next + 8'd1;
        left_dec  = left_next - 8'd1;

        fail      = 1'b0;
        fail_code = V_OK;
        results   = '0;

        unique case (ph)
            PH_PRE0:
            begin
                fail       = (rx_byte != PREAMBLE_ZERO);
                fail_code  = V_PREAMBLE;
                phase_next = PH_PRE1;
            end
            PH_PRE1:
            begin
                fail       = (rx_byte != PREAMBLE_ZERO);
                fail_code  = V_PREAMBLE;
                phase_next = PH_PRE2;
            end
            PH_PRE2:
            begin
                fail       = (rx_byte != PREAMBLE_END);
                fail_code  = V_PREAMBLE;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next   = rx_byte;
                phase_next = PH_LCS;
            end
            PH_LCS:
            begin
                fail       = (len_sum != 8'd0) || (len_next < HEADER_BYTES);
                fail_code  = V_LENGTH;
                phase_next = PH_TFI;
            end
            PH_TFI:
            begin
                fail       = (rx_byte != DIR_TO_HOST);
                fail_code  = V_RESPONSE;
                phase_next = PH_CODE;
            end
            PH_CODE:
            begin
                fail       = (rx_byte != cfg.expected_response_code);
                fail_code  = V_RESPONSE;
                phase_next = PH_STATUS;
            end
            PH_STATUS:
            begin
                // limit is latched here; empty payload closes the frame at once
                left_next  = n_payload;
                fail       = ((rx_byte & STATUS_MASK) != 8'd0) || (n_payload == 8'd0);
                fail_code  = ((rx_byte & STATUS_MASK) != 8'd0) ? V_STATUS : V_OK;
                phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                count_next            = count_inc;
                left_next             = left_dec;
                results.count         = 2'd1;
                results.first.kind    = KIND_PAYLOAD;
                results.first.data    = rx_byte;
                results.first.verdict = V_OK;
                results.first.payload_count = count_inc;
                results.first.last    = 1'b0;
                // last payload byte also closes the frame
                if (left_dec == 8'd0)
                begin
                    results.count                = 2'd2;
                    results.second.kind          = KIND_VERDICT;
                    results.second.data          = 8'd0;
                    results.second.verdict       = V_OK;
                    results.second.payload_count = count_inc;
                    results.second.last          = 1'b1;
                    phase_next                   = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // verdict item on a check that ends the frame
        if (fail)
        begin
            results.count               = 2'd1;
            results.first.kind          = KIND_VERDICT;
            results.first.data          = 8'd0;
            results.first.verdict       = fail_code;
            results.first.payload_count = count_next;
            results.first.last          = 1'b1;
            phase_next                  = PH_DONE;
        end
    end

endmodule

/* hdl/nfcrp_result_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcrp_result_queue
// Small result FIFO: takes up to two results per cycle, sends one per transfer.
// ----------------------------------------------------------------------------
module nfcrp_result_queue
    import nfcrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_pair_t push,
    output logic         room,
    nfcrp_res_if.source  res
);

    result_t               entry_reg [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RESQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RESQ_CNT_W-1:0] fill_reg,   fill_next;
    logic                  pop;
    logic [RESQ_PTR_W-1:0] wr_ptr_plus1;
    result_t               head;

    // room for a full pair, judged on the registered fill level
    assign room         = (fill_reg <= RESQ_CNT_W'(RESQ_DEPTH - 2));
    assign pop          = res.valid & res.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + RESQ_PTR_W'(1);

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RESQ_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + RESQ_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + RESQ_CNT_W'(push.count) - RESQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    // Head of queue drives the result channel
    assign head              = entry_reg[rd_ptr_reg];
    assign res.valid         = (fill_reg != '0);
    assign res.kind          = head.kind;
    assign res.data          = head.data;
    assign res.verdict       = head.verdict;
    assign res.payload_count = head.payload_count;
    assign res.last          = head.last;

endmodule
